// ----- sv/tlv_varlen_stream_parser_unit_assert.svh -----
// Assertion macros shared by the parser modules.
// Each use expects clk_i and rst_ni in the enclosing module.
`ifndef TLV_VARLEN_STREAM_PARSER_UNIT_ASSERT_SVH
`define TLV_VARLEN_STREAM_PARSER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TVSP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define TVSP_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define TVSP_ASSERT(name, prop, msg)

`define TVSP_ASSERT_NEVER(name, expr, msg)

`endif

`endif

// ----- sv/tvsp_pkg.sv -----
package tvsp_pkg;

  localparam int unsigned LEN_BYTES = 2;
  localparam int unsigned LEN_CNT_W = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 14;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned EXP_W     = 4;
  localparam int unsigned TDATA_W   = 48;

  localparam logic [EXP_W-1:0] EXP_RESET = 4'd4;
  localparam logic [CNT_W-1:0] CNT_MAX   = 5'd31;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_VALUE
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_LEN,
    ERR_COUNT,
    ERR_ORDER
  } err_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } in_t;

  typedef struct packed {
    logic              value_valid;
    logic [BYTE_W-1:0] node_type;
    logic [BYTE_W-1:0] value_byte;
    logic [LEN_W-1:0]  value_offset;
    logic [LEN_W-1:0]  node_length;
    logic              node_end;
    logic              done_res;
    err_e              status;
  } res_t;

endpackage

// ----- sv/tvsp_in_stage.sv -----
module tvsp_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  tvsp_pkg::in_t in_i,
  output logic          valid_o,
  input  logic          ready_i,
  output tvsp_pkg::in_t item_o
);
  import tvsp_pkg::*;

  logic valid_q;
  in_t  item_q;

  // The register frees up in the same cycle in which its item moves on.
  assign in_ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- sv/tvsp_parse.sv -----
`include "tlv_varlen_stream_parser_unit_assert.svh"

module tvsp_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tvsp_pkg::EXP_W-1:0] cfg_wdata_i,
  input  logic                       take_i,
  input  tvsp_pkg::in_t              item_i,
  output tvsp_pkg::res_t             res_o
);
  import tvsp_pkg::*;

  logic [EXP_W-1:0]     exp_q;
  phase_e               phase_q, phase_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [BYTE_W-1:0]    type_q, type_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [LEN_CNT_W-1:0] used_q, used_d;
  logic [LEN_W-1:0]     pos_q, pos_d;
  err_e                 pend_q, pend_d;
  err_e                 ferr_q, ferr_d;

  logic [CNT_W-1:0]     cnt_inc;
  logic [LEN_W-1:0]     len_next;
  logic [LEN_CNT_W-1:0] used_next;
  logic [LEN_W:0]       pos_inc;
  logic                 val_end;
  logic [BYTE_W-1:0]    b;
  logic                 last;

  assign b         = item_i.data_byte;
  assign last      = item_i.last_byte;
  assign cnt_inc   = (cnt_q < CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign len_next  = {len_q[LEN_W-8:0], b[6:0]};
  assign used_next = used_q + 1'b1;
  assign pos_inc   = {1'b0, pos_q} + 1'b1;
  assign val_end   = (pos_inc == {1'b0, len_q});

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    type_d  = type_q;
    len_d   = len_q;
    used_d  = used_q;
    pos_d   = pos_q;
    pend_d  = pend_q;
    ferr_d  = ferr_q;

    res_o = '0;

    if (take_i && ferr_q == ERR_NONE) begin
      unique case (phase_q)
        PH_TYPE: begin
          type_d = b;
          cnt_d  = cnt_inc;
          // A count overflow hides an out-of-order type in the same record.
          if (cnt_inc > {1'b0, exp_q}) begin
            pend_d = ERR_COUNT;
          end else if ({3'b000, cnt_inc} != b) begin
            pend_d = ERR_ORDER;
          end else begin
            pend_d = ERR_NONE;
          end
          len_d   = '0;
          used_d  = '0;
          pos_d   = '0;
          phase_d = PH_LEN;
          if (last) begin
            ferr_d = ERR_LEN;
          end
        end
        PH_LEN: begin
          len_d  = len_next;
          used_d = used_next;
          if (!b[7]) begin
            if (len_next == '0) begin
              ferr_d = ERR_LEN;
            end else begin
              phase_d = PH_VALUE;
              if (last) begin
                ferr_d = ERR_LEN;
              end
            end
          end else if (used_next >= LEN_CNT_W'(LEN_BYTES) || last) begin
            ferr_d = ERR_LEN;
          end
        end
        PH_VALUE: begin
          if (pend_q == ERR_NONE) begin
            res_o.value_valid  = 1'b1;
            res_o.value_byte   = b;
            res_o.value_offset = pos_q;
            res_o.node_end     = val_end;
          end
          if (val_end) begin
            phase_d = PH_TYPE;
            if (pend_q != ERR_NONE) begin
              ferr_d = pend_q;
            end else if (last && cnt_q != {1'b0, exp_q}) begin
              ferr_d = ERR_COUNT;
            end
          end else begin
            pos_d = pos_inc[LEN_W-1:0];
            if (last) begin
              ferr_d = ERR_LEN;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end

    res_o.node_type   = type_d;
    res_o.node_length = len_d;
    res_o.done_res    = last;
    res_o.status      = last ? ferr_d : ERR_NONE;

    // The end of a buffer puts everything but the register back to reset.
    if (take_i && last) begin
      phase_d = PH_TYPE;
      cnt_d   = '0;
      type_d  = '0;
      len_d   = '0;
      used_d  = '0;
      pos_d   = '0;
      pend_d  = ERR_NONE;
      ferr_d  = ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= EXP_RESET;
    end else if (cfg_we_i) begin
      exp_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      cnt_q   <= '0;
      type_q  <= '0;
      len_q   <= '0;
      used_q  <= '0;
      pos_q   <= '0;
      pend_q  <= ERR_NONE;
      ferr_q  <= ERR_NONE;
    end else if (take_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      type_q  <= type_d;
      len_q   <= len_d;
      used_q  <= used_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
      ferr_q  <= ferr_d;
    end
  end

  `TVSP_ASSERT(a_buf_end_clears, take_i && last |=> phase_q == PH_TYPE && cnt_q == '0 && ferr_q == ERR_NONE && pend_q == ERR_NONE, "state not cleared after buffer end")
  `TVSP_ASSERT(a_value_clean, take_i && res_o.value_valid |-> phase_q == PH_VALUE && pend_q == ERR_NONE && ferr_q == ERR_NONE, "value byte passed from a failed record")
  `TVSP_ASSERT(a_error_sticky, take_i && !last && ferr_q != ERR_NONE |=> ferr_q == $past(ferr_q) && phase_q == $past(phase_q), "error state changed before buffer end")
  `TVSP_ASSERT_NEVER(a_status_only_at_end, res_o.status != ERR_NONE && !res_o.done_res, "status reported off the last byte")

endmodule

// ----- sv/tvsp_out_stage.sv -----
module tvsp_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  tvsp_pkg::res_t res_i,
  output logic           valid_o,
  input  logic           ready_i,
  output tvsp_pkg::res_t res_o
);
  import tvsp_pkg::*;

  logic valid_q;
  res_t res_q;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- sv/tlv_varlen_stream_parser_unit.sv -----
// TLV record parser with base-128 lengths, one buffer byte per item.
// Each item is held in the input register, then its result in the output register.
// Throughput: one item per cycle; the input register, the parse logic and the output
// register form a two-stage pipeline whose ready chain stalls only on m_axis_tready.
// Reset (rst_ni low, asynchronous) empties both stages, restarts the buffer and sets
// expected_nodes to 4.
module tlv_varlen_stream_parser_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tvsp_pkg::EXP_W-1:0]   cfg_wdata_i,   // expected_nodes
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tlast,  // last_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [7:0] node_type, [15:8] value_byte, [29:16] value_offset,
  // [43:30] node_length, [44] node_end, [46:45] status, [47] zero
  output logic [tvsp_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                         m_axis_tuser,  // value_valid
  output logic                         m_axis_tlast   // done_res
);
  import tvsp_pkg::*;

  in_t  in_item;
  in_t  st_item;
  logic st_valid;
  logic out_ready;
  res_t res_d;
  res_t res_q;

  assign in_item.data_byte = s_axis_tdata;
  assign in_item.last_byte = s_axis_tlast;

  tvsp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_i       (in_item),
    .valid_o    (st_valid),
    .ready_i    (out_ready),
    .item_o     (st_item)
  );

  tvsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (st_valid && out_ready),
    .item_i      (st_item),
    .res_o       (res_d)
  );

  tvsp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (st_valid),
    .ready_o (out_ready),
    .res_i   (res_d),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_q)
  );

  assign m_axis_tdata = {1'b0, res_q.status, res_q.node_end, res_q.node_length,
                         res_q.value_offset, res_q.value_byte, res_q.node_type};
  assign m_axis_tuser = res_q.value_valid;
  assign m_axis_tlast = res_q.done_res;

endmodule
